### hdl/disk_pair_elastic_collision_assert.svh
// assertion macros for the disk pair collision pipeline
// expects aclk and aresetn in the scope of the module that uses them
`ifndef DISK_PAIR_ELASTIC_COLLISION_ASSERT_SVH
`define DISK_PAIR_ELASTIC_COLLISION_ASSERT_SVH

// same-cycle implication
`define DPEC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dpec assertion failed");

// next-cycle implication
`define DPEC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dpec assertion failed");

`endif

### hdl/dpec_pkg.sv
// shared types, widths and saturation helper for the disk pair collision block
// no dependencies
package dpec_pkg;

    localparam int POS_W  = 20;
    localparam int RAD_W  = 16;
    localparam int MASS_W = 16;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] first_pos_x;
        logic signed [POS_W-1:0] first_pos_y;
        logic signed [POS_W-1:0] first_vel_x;
        logic signed [POS_W-1:0] first_vel_y;
        logic [RAD_W-1:0]        first_radius;
        logic [MASS_W-1:0]       first_mass;
        logic signed [POS_W-1:0] second_pos_x;
        logic signed [POS_W-1:0] second_pos_y;
        logic signed [POS_W-1:0] second_vel_x;
        logic signed [POS_W-1:0] second_vel_y;
        logic [RAD_W-1:0]        second_radius;
        logic [MASS_W-1:0]       second_mass;
    } dpec_in_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] new_first_pos_x;
        logic signed [POS_W-1:0] new_first_pos_y;
        logic signed [POS_W-1:0] new_first_vel_x;
        logic signed [POS_W-1:0] new_first_vel_y;
        logic signed [POS_W-1:0] new_second_pos_x;
        logic signed [POS_W-1:0] new_second_pos_y;
        logic signed [POS_W-1:0] new_second_vel_x;
        logic signed [POS_W-1:0] new_second_vel_y;
    } dpec_out_t;

    function automatic logic signed [POS_W-1:0] dpec_sat(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        hi = (POS_W+2)'(POS_MAX);
        lo = (POS_W+2)'(POS_MIN);
        if (v > hi) begin
            return POS_MAX;
        end else if (v < lo) begin
            return POS_MIN;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

endpackage

### hdl/dpec_delay.sv
// shift line that carries payload alongside the arithmetic units
// no dependencies
module dpec_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sr_reg [0:D-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[D-1];

endmodule

### hdl/dpec_wmul.sv
// two-stage signed multiplier, wide operand split into two partial products
// no dependencies
module dpec_wmul #(
    parameter int AW = 40,
    parameter int BW = 18
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LW = AW / 2;
    localparam int HW = AW - LW;

    logic signed [LW:0]         a_lo;
    logic signed [HW-1:0]       a_hi;
    logic signed [LW+BW:0]      pl_reg;
    logic signed [HW+BW-1:0]    ph_reg;
    logic signed [AW+BW-1:0]    p_next;
    logic signed [AW+BW-1:0]    p_reg;

    assign a_lo = $signed({1'b0, a[LW-1:0]});
    assign a_hi = a[AW-1:LW];

    always_comb begin
        p_next = ((AW+BW)'(ph_reg) <<< LW) + (AW+BW)'(pl_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg <= a_lo * b;
            ph_reg <= a_hi * b;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### hdl/dpec_rdiv.sv
// pipelined restoring divider, one quotient bit per stage
// rounds to nearest with ties away from zero, clamps when the quotient overflows
module dpec_rdiv #(
    parameter int NW = 58,
    parameter int DW = 17,
    parameter int QW = 39
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic signed [QW:0]   q
);

    localparam int CW = ((NW + 1 > DW + QW) ? NW + 1 : DW + QW) + 1;

    logic [CW-1:0]      rem_reg [0:QW];
    logic [QW-1:0]      quo_reg [0:QW];
    logic [DW-1:0]      den_reg [0:QW];
    logic               neg_reg [0:QW];
    logic               ovf_reg [0:QW];
    logic [CW-1:0]      sub_w   [0:QW-1];
    logic               ge_w    [0:QW-1];
    logic [NW-1:0]      mag0;
    logic [CW-1:0]      a0;
    logic               ovf0;
    logic signed [QW:0] qmag;
    logic signed [QW:0] q_next;
    logic signed [QW:0] q_reg;

    always_comb begin
        mag0 = num[NW-1] ? NW'(-num) : NW'(num);
        a0   = CW'(mag0) + CW'(den >> 1);
        ovf0 = a0 >= (CW'(den) << QW);
        for (int k = 0; k < QW; k++) begin
            sub_w[k] = CW'(den_reg[k]) << (QW - 1 - k);
            ge_w[k]  = rem_reg[k] >= sub_w[k];
        end
        qmag = $signed({1'b0, quo_reg[QW]});
        if (ovf_reg[QW]) begin
            q_next = neg_reg[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
        end else begin
            q_next = neg_reg[QW] ? -qmag : qmag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= a0;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[NW-1];
            ovf_reg[0] <= ovf0;
            for (int k = 0; k < QW; k++) begin
                rem_reg[k+1] <= ge_w[k] ? rem_reg[k] - sub_w[k] : rem_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (ge_w[k] ? (QW'(1) << (QW - 1 - k)) : '0);
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### hdl/dpec_isqrt.sv
// pipelined integer square root, one result bit per stage
// no dependencies
module dpec_isqrt #(
    parameter int XW = 42
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [XW-1:0]     x,
    output logic [XW/2-1:0]   root
);

    localparam int RW = XW / 2;
    localparam int SW = XW + 1;

    logic [SW-1:0] x_reg   [1:RW];
    logic [SW-1:0] r_reg   [1:RW];
    logic [SW-1:0] x_cur   [0:RW-1];
    logic [SW-1:0] r_cur   [0:RW-1];
    logic [SW-1:0] bit_w   [0:RW-1];
    logic [SW-1:0] trial_w [0:RW-1];
    logic          ge_w    [0:RW-1];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                x_cur[k] = SW'(x);
                r_cur[k] = '0;
            end else begin
                x_cur[k] = x_reg[k];
                r_cur[k] = r_reg[k];
            end
            bit_w[k]   = SW'(1) << (2 * (RW - 1 - k));
            trial_w[k] = r_cur[k] + bit_w[k];
            ge_w[k]    = x_cur[k] >= trial_w[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < RW; k++) begin
                x_reg[k+1] <= ge_w[k] ? x_cur[k] - trial_w[k] : x_cur[k];
                r_reg[k+1] <= ge_w[k] ? (r_cur[k] >> 1) + bit_w[k] : r_cur[k] >> 1;
            end
        end
    end

    assign root = r_reg[RW][RW-1:0];

endmodule

### hdl/disk_pair_elastic_collision.sv
// one pair accepted per cycle while the skid entry is empty (s_ready follows it)
// depth is set by the 21-stage square root, the 41-stage mass division and
// the 22-stage velocity division, chained with short multiply stages
// an output register plus one skid entry hold the transactions in flight when m_ready drops
// reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset
`include "disk_pair_elastic_collision_assert.svh"
module disk_pair_elastic_collision
    import dpec_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dpec_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output dpec_out_t m_data
);

    localparam int DXW  = POS_W + 1;
    localparam int D2W  = 2 * DXW;
    localparam int RTW  = D2W / 2;
    localparam int SUMW = RAD_W + 1;
    localparam int DHW  = SUMW + 1;
    localparam int PPW  = 2 * DHW;
    localparam int VPW  = POS_W + DHW;
    localparam int NPW  = VPW + 1;
    localparam int MBW  = MASS_W + 2;
    localparam int PMW  = NPW + MBW;
    localparam int NUMW = PMW + 1;
    localparam int MQW  = NUMW - MASS_W - 3;
    localparam int MVW  = MQW + 1;
    localparam int VMW  = MVW + DHW;
    localparam int VNW  = VMW + 1;
    localparam int DQW  = 2 * SUMW;
    localparam int VQW  = POS_W;
    localparam int SQW  = SUMW;
    localparam int MSW  = MASS_W + 1;

    localparam int WMUL_LAT = 2;
    localparam int T_HIT = RTW + 4;
    localparam int T_MS  = T_HIT + 3 + WMUL_LAT;
    localparam int T_M   = T_MS + MQW + 2;
    localparam int T_VN  = T_M + WMUL_LAT + 1;
    localparam int T_VQ  = T_VN + VQW + 2;
    localparam int T_SX  = T_HIT + 1 + SQW + 2;
    localparam int LAT   = T_VQ + 1;

    logic pipe_en;
    logic [LAT:1] vld_reg;

    // front: differences, squares, square root
    dpec_in_t                in1_reg;
    logic signed [DXW-1:0]   dx1_reg, dy1_reg;
    logic signed [D2W-1:0]   sqx, sqy;
    logic [D2W-2:0]          dx2_reg, dy2_reg;
    logic [SUMW-1:0]         sumr2_reg;
    logic [D2W-1:0]          d2_3_reg;
    logic [RTW-1:0]          dist_w;
    logic signed [DXW-1:0]   dx24, dy24;
    logic [SUMW-1:0]         sumr24;
    logic [D2W-1:0]          d2_24;
    dpec_in_t                in25;

    // hit decision stage
    logic                    hit25_reg;
    logic [SUMW-1:0]         pen25_reg;
    logic signed [DHW-1:0]   dxh25_reg, dyh25_reg;
    logic [DHW-1:0]          dist2_25_reg;
    logic [DQW-1:0]          d2h25_reg;
    logic [MASS_W-1:0]       m1e, m2e;
    logic [MSW-1:0]          w1_25_reg, w2_25_reg, ms25_reg;
    logic signed [MSW-1:0]   c1_25_reg, c2_25_reg;

    // velocity projections
    logic signed [PPW-1:0]   ppx26_reg, ppy26_reg;
    logic [DHW-1:0]          den26_reg;
    logic signed [VPW-1:0]   a1_reg, b1_reg, e1_reg, f1_reg;
    logic signed [VPW-1:0]   a2_reg, b2_reg, e2_reg, f2_reg;
    logic signed [NPW-1:0]   n1_27_reg, t1_27_reg, n2_27_reg, t2_27_reg;
    logic [4*MSW-1:0]        mass27;
    logic [MSW-1:0]          w1_27, w2_27;
    logic signed [MSW-1:0]   c1_27, c2_27;
    logic signed [PMW-1:0]   pa, pb, pc, pd;
    logic signed [NUMW-1:0]  num1_reg, num2_reg;
    logic [MSW-1:0]          ms30;
    logic signed [MVW-1:0]   mm1, mm2;
    logic signed [NPW-1:0]   t1_71, t2_71;
    logic signed [DHW-1:0]   dx71, dy71;
    logic signed [VMW-1:0]   m1dx, m1dy, m2dx, m2dy;
    logic signed [VMW-2:0]   t1dy, t1dx, t2dy, t2dx;
    logic signed [VNW-1:0]   v1xn_reg, v1yn_reg, v2xn_reg, v2yn_reg;
    logic [DQW-1:0]          d2h74;
    logic signed [VQW:0]     q1x, q1y, q2x, q2y;

    // separation
    logic signed [SQW:0]     sx45, sy45, sx96, sy96;
    logic                    hit96;
    dpec_in_t                in96;

    dpec_out_t               res_next;
    dpec_out_t               res_reg;
    dpec_out_t               m_data_reg, skid_data_reg;
    logic                    m_valid_reg, skid_valid_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_comb begin
        sqx = dx1_reg * dx1_reg;
        sqy = dy1_reg * dy1_reg;
        if (in25.first_mass == '0 && in25.second_mass == '0) begin
            m1e = MASS_W'(1);
            m2e = MASS_W'(1);
        end else begin
            m1e = in25.first_mass;
            m2e = in25.second_mass;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in1_reg   <= s_data;
            dx1_reg   <= DXW'(s_data.first_pos_x) - DXW'(s_data.second_pos_x);
            dy1_reg   <= DXW'(s_data.first_pos_y) - DXW'(s_data.second_pos_y);
            dx2_reg   <= sqx[D2W-2:0];
            dy2_reg   <= sqy[D2W-2:0];
            sumr2_reg <= SUMW'(in1_reg.first_radius) + SUMW'(in1_reg.second_radius);
            d2_3_reg  <= D2W'(dx2_reg) + D2W'(dy2_reg);

            hit25_reg    <= (d2_24 != '0) && (dist_w < RTW'(sumr24));
            pen25_reg    <= sumr24 - dist_w[SUMW-1:0];
            dxh25_reg    <= dx24[DHW-1:0];
            dyh25_reg    <= dy24[DHW-1:0];
            dist2_25_reg <= {dist_w[SUMW-1:0], 1'b0};
            d2h25_reg    <= d2_24[DQW-1:0];
            w1_25_reg    <= {m2e, 1'b0};
            w2_25_reg    <= {m1e, 1'b0};
            c1_25_reg    <= $signed(MSW'(m1e)) - $signed(MSW'(m2e));
            c2_25_reg    <= $signed(MSW'(m2e)) - $signed(MSW'(m1e));
            ms25_reg     <= MSW'(m1e) + MSW'(m2e);

            ppx26_reg <= $signed({1'b0, pen25_reg}) * dxh25_reg;
            ppy26_reg <= $signed({1'b0, pen25_reg}) * dyh25_reg;
            den26_reg <= dist2_25_reg;
            a1_reg    <= in25.first_vel_x * dxh25_reg;
            b1_reg    <= in25.first_vel_y * dyh25_reg;
            e1_reg    <= in25.first_vel_y * dxh25_reg;
            f1_reg    <= in25.first_vel_x * dyh25_reg;
            a2_reg    <= in25.second_vel_x * dxh25_reg;
            b2_reg    <= in25.second_vel_y * dyh25_reg;
            e2_reg    <= in25.second_vel_y * dxh25_reg;
            f2_reg    <= in25.second_vel_x * dyh25_reg;

            n1_27_reg <= NPW'(a1_reg) + NPW'(b1_reg);
            t1_27_reg <= NPW'(e1_reg) - NPW'(f1_reg);
            n2_27_reg <= NPW'(a2_reg) + NPW'(b2_reg);
            t2_27_reg <= NPW'(e2_reg) - NPW'(f2_reg);

            num1_reg <= NUMW'(pa) + NUMW'(pb);
            num2_reg <= NUMW'(pc) + NUMW'(pd);

            v1xn_reg <= VNW'(m1dx) - VNW'(t1dy);
            v1yn_reg <= VNW'(m1dy) + VNW'(t1dx);
            v2xn_reg <= VNW'(m2dx) - VNW'(t2dy);
            v2yn_reg <= VNW'(m2dy) + VNW'(t2dx);

            res_reg <= res_next;
        end
    end

    dpec_isqrt #(.XW(D2W)) u_isqrt (
        .aclk(aclk), .en(pipe_en), .x(d2_3_reg), .root(dist_w)
    );

    dpec_delay #(.W(DXW), .D(RTW + 2)) u_dly_dx (
        .aclk(aclk), .en(pipe_en), .din(dx1_reg), .dout(dx24)
    );
    dpec_delay #(.W(DXW), .D(RTW + 2)) u_dly_dy (
        .aclk(aclk), .en(pipe_en), .din(dy1_reg), .dout(dy24)
    );
    dpec_delay #(.W(SUMW), .D(RTW + 1)) u_dly_sumr (
        .aclk(aclk), .en(pipe_en), .din(sumr2_reg), .dout(sumr24)
    );
    dpec_delay #(.W(D2W), .D(RTW)) u_dly_d2 (
        .aclk(aclk), .en(pipe_en), .din(d2_3_reg), .dout(d2_24)
    );
    dpec_delay #(.W($bits(dpec_in_t)), .D(T_HIT - 1)) u_dly_in25 (
        .aclk(aclk), .en(pipe_en), .din(in1_reg), .dout(in25)
    );

    // mass-weighted normal components
    dpec_delay #(.W(4 * MSW), .D(1)) u_dly_mass (
        .aclk(aclk), .en(pipe_en),
        .din({w1_25_reg, w2_25_reg, c1_25_reg, c2_25_reg}), .dout(mass27)
    );
    assign w1_27 = mass27[4*MSW-1:3*MSW];
    assign w2_27 = mass27[3*MSW-1:2*MSW];
    assign c1_27 = $signed(mass27[2*MSW-1:MSW]);
    assign c2_27 = $signed(mass27[MSW-1:0]);

    dpec_wmul #(.AW(NPW), .BW(MBW)) u_mul_pa (
        .aclk(aclk), .en(pipe_en), .a(n2_27_reg), .b($signed({1'b0, w1_27})), .p(pa)
    );
    dpec_wmul #(.AW(NPW), .BW(MBW)) u_mul_pb (
        .aclk(aclk), .en(pipe_en), .a(n1_27_reg), .b(MBW'(c1_27)), .p(pb)
    );
    dpec_wmul #(.AW(NPW), .BW(MBW)) u_mul_pc (
        .aclk(aclk), .en(pipe_en), .a(n1_27_reg), .b($signed({1'b0, w2_27})), .p(pc)
    );
    dpec_wmul #(.AW(NPW), .BW(MBW)) u_mul_pd (
        .aclk(aclk), .en(pipe_en), .a(n2_27_reg), .b(MBW'(c2_27)), .p(pd)
    );

    dpec_delay #(.W(MSW), .D(T_MS - T_HIT - 1)) u_dly_ms (
        .aclk(aclk), .en(pipe_en), .din(ms25_reg), .dout(ms30)
    );

    dpec_rdiv #(.NW(NUMW), .DW(MSW), .QW(MQW)) u_div_m1 (
        .aclk(aclk), .en(pipe_en), .num(num1_reg), .den(ms30), .q(mm1)
    );
    dpec_rdiv #(.NW(NUMW), .DW(MSW), .QW(MQW)) u_div_m2 (
        .aclk(aclk), .en(pipe_en), .num(num2_reg), .den(ms30), .q(mm2)
    );

    dpec_delay #(.W(NPW), .D(T_M - T_HIT - 2)) u_dly_t1 (
        .aclk(aclk), .en(pipe_en), .din(t1_27_reg), .dout(t1_71)
    );
    dpec_delay #(.W(NPW), .D(T_M - T_HIT - 2)) u_dly_t2 (
        .aclk(aclk), .en(pipe_en), .din(t2_27_reg), .dout(t2_71)
    );
    dpec_delay #(.W(DHW), .D(T_M - T_HIT)) u_dly_dxh (
        .aclk(aclk), .en(pipe_en), .din(dxh25_reg), .dout(dx71)
    );
    dpec_delay #(.W(DHW), .D(T_M - T_HIT)) u_dly_dyh (
        .aclk(aclk), .en(pipe_en), .din(dyh25_reg), .dout(dy71)
    );

    // back to x/y frame
    dpec_wmul #(.AW(MVW), .BW(DHW)) u_mul_m1dx (
        .aclk(aclk), .en(pipe_en), .a(mm1), .b(dx71), .p(m1dx)
    );
    dpec_wmul #(.AW(MVW), .BW(DHW)) u_mul_m1dy (
        .aclk(aclk), .en(pipe_en), .a(mm1), .b(dy71), .p(m1dy)
    );
    dpec_wmul #(.AW(MVW), .BW(DHW)) u_mul_m2dx (
        .aclk(aclk), .en(pipe_en), .a(mm2), .b(dx71), .p(m2dx)
    );
    dpec_wmul #(.AW(MVW), .BW(DHW)) u_mul_m2dy (
        .aclk(aclk), .en(pipe_en), .a(mm2), .b(dy71), .p(m2dy)
    );
    dpec_wmul #(.AW(NPW), .BW(DHW)) u_mul_t1dy (
        .aclk(aclk), .en(pipe_en), .a(t1_71), .b(dy71), .p(t1dy)
    );
    dpec_wmul #(.AW(NPW), .BW(DHW)) u_mul_t1dx (
        .aclk(aclk), .en(pipe_en), .a(t1_71), .b(dx71), .p(t1dx)
    );
    dpec_wmul #(.AW(NPW), .BW(DHW)) u_mul_t2dy (
        .aclk(aclk), .en(pipe_en), .a(t2_71), .b(dy71), .p(t2dy)
    );
    dpec_wmul #(.AW(NPW), .BW(DHW)) u_mul_t2dx (
        .aclk(aclk), .en(pipe_en), .a(t2_71), .b(dx71), .p(t2dx)
    );

    dpec_delay #(.W(DQW), .D(T_VN - T_HIT)) u_dly_d2h (
        .aclk(aclk), .en(pipe_en), .din(d2h25_reg), .dout(d2h74)
    );

    dpec_rdiv #(.NW(VNW), .DW(DQW), .QW(VQW)) u_div_v1x (
        .aclk(aclk), .en(pipe_en), .num(v1xn_reg), .den(d2h74), .q(q1x)
    );
    dpec_rdiv #(.NW(VNW), .DW(DQW), .QW(VQW)) u_div_v1y (
        .aclk(aclk), .en(pipe_en), .num(v1yn_reg), .den(d2h74), .q(q1y)
    );
    dpec_rdiv #(.NW(VNW), .DW(DQW), .QW(VQW)) u_div_v2x (
        .aclk(aclk), .en(pipe_en), .num(v2xn_reg), .den(d2h74), .q(q2x)
    );
    dpec_rdiv #(.NW(VNW), .DW(DQW), .QW(VQW)) u_div_v2y (
        .aclk(aclk), .en(pipe_en), .num(v2yn_reg), .den(d2h74), .q(q2y)
    );

    // half-overlap push along the center line
    dpec_rdiv #(.NW(PPW), .DW(DHW), .QW(SQW)) u_div_sx (
        .aclk(aclk), .en(pipe_en), .num(ppx26_reg), .den(den26_reg), .q(sx45)
    );
    dpec_rdiv #(.NW(PPW), .DW(DHW), .QW(SQW)) u_div_sy (
        .aclk(aclk), .en(pipe_en), .num(ppy26_reg), .den(den26_reg), .q(sy45)
    );
    dpec_delay #(.W(SQW + 1), .D(T_VQ - T_SX)) u_dly_sx (
        .aclk(aclk), .en(pipe_en), .din(sx45), .dout(sx96)
    );
    dpec_delay #(.W(SQW + 1), .D(T_VQ - T_SX)) u_dly_sy (
        .aclk(aclk), .en(pipe_en), .din(sy45), .dout(sy96)
    );

    dpec_delay #(.W(1), .D(T_VQ - T_HIT)) u_dly_hit (
        .aclk(aclk), .en(pipe_en), .din(hit25_reg), .dout(hit96)
    );
    dpec_delay #(.W($bits(dpec_in_t)), .D(T_VQ - T_HIT)) u_dly_in96 (
        .aclk(aclk), .en(pipe_en), .din(in25), .dout(in96)
    );

    always_comb begin
        res_next.hit = hit96;
        if (hit96) begin
            res_next.new_first_pos_x  = dpec_sat((POS_W+2)'(in96.first_pos_x) + (POS_W+2)'(sx96));
            res_next.new_first_pos_y  = dpec_sat((POS_W+2)'(in96.first_pos_y) + (POS_W+2)'(sy96));
            res_next.new_second_pos_x = dpec_sat((POS_W+2)'(in96.second_pos_x) - (POS_W+2)'(sx96));
            res_next.new_second_pos_y = dpec_sat((POS_W+2)'(in96.second_pos_y) - (POS_W+2)'(sy96));
            res_next.new_first_vel_x  = dpec_sat((POS_W+2)'(q1x));
            res_next.new_first_vel_y  = dpec_sat((POS_W+2)'(q1y));
            res_next.new_second_vel_x = dpec_sat((POS_W+2)'(q2x));
            res_next.new_second_vel_y = dpec_sat((POS_W+2)'(q2y));
        end else begin
            res_next.new_first_pos_x  = in96.first_pos_x;
            res_next.new_first_pos_y  = in96.first_pos_y;
            res_next.new_second_pos_x = in96.second_pos_x;
            res_next.new_second_pos_y = in96.second_pos_y;
            res_next.new_first_vel_x  = in96.first_vel_x;
            res_next.new_first_vel_y  = in96.first_vel_y;
            res_next.new_second_vel_x = in96.second_vel_x;
            res_next.new_second_vel_y = in96.second_vel_y;
        end
    end

    // valid bits and output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pipe_en) begin
                vld_reg <= {vld_reg[LAT-1:1], s_valid};
                if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= vld_reg[LAT];
                end else begin
                    skid_valid_reg <= vld_reg[LAT];
                end
            end else if (m_ready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= res_reg;
            end else begin
                skid_data_reg <= res_reg;
            end
        end else if (m_ready) begin
            m_data_reg <= skid_data_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DPEC_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, m_valid_reg)
    `DPEC_ASSERT_NXT(a_skid_drains, skid_valid_reg && m_ready, !skid_valid_reg)
    `DPEC_ASSERT_NXT(a_pipe_frozen, !pipe_en, $stable(vld_reg))

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for disk_pair_elastic_collision: directed table, then random pairs
// depends on dpec_pkg and the disk_pair_elastic_collision rtl
`timescale 1ns / 1ps
module tb_top
    import dpec_pkg::*;
();

    localparam int N_RANDOM  = 1680;
    localparam int CYC_LIMIT = 600000;
    localparam int DRAIN     = 200;

    typedef struct {
        dpec_in_t  pair;
        bit        known;
        dpec_out_t res;
    } row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    dpec_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    dpec_out_t m_data;

    logic s_fire;
    logic m_fire;
    bit   hold_req;
    bit   rx_burst;
    int   n_err = 0;
    int   n_cyc = 0;
    int   n_res = 0;

    row_t      rows[$];
    row_t      offered_q[$];
    dpec_out_t collision_q[$];

    disk_pair_elastic_collision DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint round_div(longint num, longint den);
        longint a;
        longint q;
        a = (num < 0) ? -num : num;
        q = (a + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint floor_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp20(longint v);
        if (v > 524287) return POS_MAX;
        if (v < -524288) return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic dpec_out_t unchanged_pair(dpec_in_t p);
        dpec_out_t o;
        o.hit              = 1'b0;
        o.new_first_pos_x  = p.first_pos_x;
        o.new_first_pos_y  = p.first_pos_y;
        o.new_first_vel_x  = p.first_vel_x;
        o.new_first_vel_y  = p.first_vel_y;
        o.new_second_pos_x = p.second_pos_x;
        o.new_second_pos_y = p.second_pos_y;
        o.new_second_vel_x = p.second_vel_x;
        o.new_second_vel_y = p.second_vel_y;
        return o;
    endfunction

    function automatic dpec_out_t resolve_collision(dpec_in_t p);
        dpec_out_t o;
        longint x1, y1, u1, w1, x2, y2, u2, w2, ma, mb;
        longint dx, dy, d2, ctr_dist, sumr, pen, sx, sy;
        longint n1, t1, n2, t2, ms, k1, k2;
        x1 = p.first_pos_x;  y1 = p.first_pos_y;
        u1 = p.first_vel_x;  w1 = p.first_vel_y;
        x2 = p.second_pos_x; y2 = p.second_pos_y;
        u2 = p.second_vel_x; w2 = p.second_vel_y;
        ma = longint'({1'b0, p.first_mass});
        mb = longint'({1'b0, p.second_mass});
        dx = x1 - x2;
        dy = y1 - y2;
        d2 = dx * dx + dy * dy;
        ctr_dist = floor_sqrt(d2);
        sumr = longint'({1'b0, p.first_radius}) + longint'({1'b0, p.second_radius});
        if (d2 == 0 || ctr_dist >= sumr) return unchanged_pair(p);
        pen = sumr - ctr_dist;
        sx = round_div(pen * dx, 2 * ctr_dist);
        sy = round_div(pen * dy, 2 * ctr_dist);
        n1 = u1 * dx + w1 * dy;  t1 = w1 * dx - u1 * dy;
        n2 = u2 * dx + w2 * dy;  t2 = w2 * dx - u2 * dy;
        if (ma == 0 && mb == 0) begin
            ma = 1;
            mb = 1;
        end
        ms = ma + mb;
        k1 = round_div(2 * mb * n2 + n1 * (ma - mb), ms);
        k2 = round_div(2 * ma * n1 + n2 * (mb - ma), ms);
        o.hit              = 1'b1;
        o.new_first_pos_x  = clamp20(x1 + sx);
        o.new_first_pos_y  = clamp20(y1 + sy);
        o.new_first_vel_x  = clamp20(round_div(k1 * dx - t1 * dy, d2));
        o.new_first_vel_y  = clamp20(round_div(k1 * dy + t1 * dx, d2));
        o.new_second_pos_x = clamp20(x2 - sx);
        o.new_second_pos_y = clamp20(y2 - sy);
        o.new_second_vel_x = clamp20(round_div(k2 * dx - t2 * dy, d2));
        o.new_second_vel_y = clamp20(round_div(k2 * dy + t2 * dx, d2));
        return o;
    endfunction

    function automatic dpec_in_t make_pair(int ax, int ay, int au, int aw, int ar, int am,
                                           int bx, int by, int bu, int bw, int br, int bm);
        dpec_in_t p;
        p.first_pos_x  = ax[POS_W-1:0]; p.first_pos_y  = ay[POS_W-1:0];
        p.first_vel_x  = au[POS_W-1:0]; p.first_vel_y  = aw[POS_W-1:0];
        p.first_radius = ar[15:0];      p.first_mass   = am[15:0];
        p.second_pos_x = bx[POS_W-1:0]; p.second_pos_y = by[POS_W-1:0];
        p.second_vel_x = bu[POS_W-1:0]; p.second_vel_y = bw[POS_W-1:0];
        p.second_radius = br[15:0];     p.second_mass  = bm[15:0];
        return p;
    endfunction

    function automatic void add_row(dpec_in_t p, bit known);
        row_t r;
        r.pair  = p;
        r.known = known;
        r.res   = unchanged_pair(p);
        rows = {rows, r};
    endfunction

    function automatic dpec_in_t random_pair();
        dpec_in_t p;
        int dx, dy;
        p = $bits(dpec_in_t)'({$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 7) begin
            dx = $urandom_range(0, 8000) - 4000;
            dy = $urandom_range(0, 8000) - 4000;
            p.second_pos_x = p.first_pos_x + dx[POS_W-1:0];
            p.second_pos_y = p.first_pos_y + dy[POS_W-1:0];
            if ($urandom_range(0, 3) != 0) begin
                p.first_radius  = RAD_W'($urandom_range(0, 4000));
                p.second_radius = RAD_W'($urandom_range(0, 4000));
            end
            if ($urandom_range(0, 3) == 0) begin
                p.first_mass  = MASS_W'($urandom_range(0, 8));
                p.second_mass = MASS_W'($urandom_range(0, 8));
            end
        end
        return p;
    endfunction

    function automatic void check_field(string name, logic signed [POS_W-1:0] exp_v,
                                        logic signed [POS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_err++;
        end
    endfunction

    always @(posedge aclk) begin
        dpec_out_t e;
        row_t      r;
        s_fire <= aresetn && s_valid && s_ready;
        m_fire <= aresetn && m_valid && m_ready;
        n_cyc  <= n_cyc + 1;
        if (aresetn && s_valid && s_ready) begin
            r = offered_q.pop_front();
            collision_q = {collision_q, (r.known ? r.res : resolve_collision(s_data))};
        end
        if (aresetn && m_valid && m_ready) begin
            n_res <= n_res + 1;
            if (collision_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_err++;
            end else begin
                e = collision_q.pop_front();
                if (e.hit !== m_data.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, m_data.hit);
                    n_err++;
                end
                check_field("new_first_pos_x", e.new_first_pos_x, m_data.new_first_pos_x);
                check_field("new_first_pos_y", e.new_first_pos_y, m_data.new_first_pos_y);
                check_field("new_first_vel_x", e.new_first_vel_x, m_data.new_first_vel_x);
                check_field("new_first_vel_y", e.new_first_vel_y, m_data.new_first_vel_y);
                check_field("new_second_pos_x", e.new_second_pos_x, m_data.new_second_pos_x);
                check_field("new_second_pos_y", e.new_second_pos_y, m_data.new_second_pos_y);
                check_field("new_second_vel_x", e.new_second_vel_x, m_data.new_second_vel_x);
                check_field("new_second_vel_y", e.new_second_vel_y, m_data.new_second_vel_y);
            end
        end
    end

    // receiver: random stalls, a stretch without stalls, and one long hold-off
    initial begin
        int k;
        bit hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            rx_burst = (n_res >= 1000 && n_res < 1200);
            k = rx_burst ? 0 : $urandom_range(0, 11);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                k = 400;
            end
            if (k > 0) begin
                m_ready <= 1'b0;
                repeat (k) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_fire);
        end
    end

    task automatic offer_pair(row_t r, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        offered_q = {offered_q, r};
        s_valid <= 1'b1;
        s_data  <= r.pair;
        do @(negedge aclk); while (!s_fire);
    endtask

    initial begin
        row_t r;
        int   gap;
        hold_req = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;

        // passthrough cases: coincident, self pair, far apart, touching
        add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row(make_pair(5000, -7000, 300, -200, 9000, 7, 5000, -7000, 300, -200, 9000, 7), 1);
        add_row(make_pair(524287, 524287, 524287, 524287, 65535, 65535,
                          -524288, -524288, -524288, -524288, 65535, 65535), 1);
        add_row(make_pair(-524288, 524287, -524288, 524287, 0, 1,
                          524287, -524288, 524287, -524288, 0, 1), 1);
        add_row(make_pair(2560, 0, 100, 0, 1280, 5, 0, 0, -100, 0, 1280, 5), 1);
        add_row(make_pair(0, 0, 256, 0, 0, 1, 0, 0, -256, 0, 0, 1), 1);
        // overlaps, checked by prediction
        add_row(make_pair(2559, 0, 100, 0, 1280, 5, 0, 0, -100, 0, 1280, 5), 0);
        add_row(make_pair(1000, 0, 512, 0, 800, 3, 0, 0, -512, 0, 800, 3), 0);
        add_row(make_pair(300, 400, 1000, -700, 500, 0, 0, 0, -300, 900, 500, 0), 0);
        add_row(make_pair(300, -400, 1000, 700, 500, 0, 0, 0, -300, 900, 500, 9), 0);
        add_row(make_pair(-700, 700, 4000, 4000, 1000, 65535, 0, 0, 0, 0, 1000, 1), 0);
        add_row(make_pair(524287, 524287, 524287, 524287, 65535, 65535,
                          524000, 524100, -524288, -524288, 65535, 65535), 0);
        add_row(make_pair(-524288, -524288, -524288, 524287, 65535, 1,
                          -524000, -523900, 524287, -524288, 65535, 65535), 0);
        add_row(make_pair(1, 0, 524287, 524287, 65535, 1, 0, 0, -524288, -524288, 65535, 1), 0);
        add_row(make_pair(0, 1, -524288, 524287, 1, 65535, 0, 0, 524287, -524288, 1, 65534), 0);
        add_row(make_pair(-123, 77, 33, -9, 200, 40, 50, -60, -17, 5, 150, 60), 0);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) offer_pair(rows[i], $urandom_range(0, 11));
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) hold_req = 1'b1;
            if (i == 900) begin
                s_valid <= 1'b0;
                while (collision_q.size() != 0 || offered_q.size() != 0) @(negedge aclk);
            end
            gap = ((i >= 300 && i < 560) || (i >= 1300 && i < 1400)) ? 0
                                                                      : $urandom_range(0, 11);
            r.pair  = random_pair();
            r.known = 1'b0;
            offer_pair(r, gap);
        end
        s_valid <= 1'b0;

        while (collision_q.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        if (n_err == 0) begin
            $display("** disk_pair_elastic_collision: PASSED **");
        end else begin
            $display("** disk_pair_elastic_collision: FAILED **");
        end
        $finish;
    end

    initial begin
        wait (n_cyc >= CYC_LIMIT);
        $error("timeout after %0d cycles", n_cyc);
        $display("** disk_pair_elastic_collision: FAILED **");
        $finish;
    end

endmodule
